// File: rtl/core/cylinder_vortex_force_core_macros.svh
// assertion macros for the vortex force core checker
// no dependencies
`ifndef CYLINDER_VORTEX_FORCE_CORE_MACROS_SVH
`define CYLINDER_VORTEX_FORCE_CORE_MACROS_SVH
// property that must hold at every clock once out of reset
`define CVF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// property that must hold at every clock, reset cycles included
`define CVF_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);
`endif

// File: rtl/core/cvf_pkg.sv
// shared types and constants for the vortex force core
// no dependencies
`timescale 1ns / 1ps
package cvf_pkg;
    localparam int DW = 32;
    localparam int FB = 16;
    localparam int DIR_FRAC = 30;

    localparam logic [1:0] REG_RADIUS = 2'd0;
    localparam logic [1:0] REG_LENGTH = 2'd1;
    localparam logic [1:0] REG_COEF   = 2'd2;
    localparam logic [1:0] REG_NZL    = 2'd3;

    typedef struct packed {
        logic signed [DW-1:0] pos_x;
        logic signed [DW-1:0] pos_y;
        logic signed [DW-1:0] pos_z;
        logic signed [DW-1:0] vel_x;
        logic signed [DW-1:0] vel_y;
        logic signed [DW-1:0] vel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [DW-1:0] force_x;
        logic signed [DW-1:0] force_y;
        logic                 in_field;
    } out_item_t;
endpackage

// File: rtl/core/cylinder_vortex_force_core.sv
// vortex force core: pipelined fixed point force, one particle per cycle unless stalled
// depends on cvf_pkg
`timescale 1ns / 1ps
// Usage
// s_valid/s_ready/s_data carry one particle item (position, velocity).
// m_valid/m_ready/m_data carry one force item (force_x, force_y, in_field).
// cfg_we/cfg_idx/cfg_data write radius, length, coefficient, near-zero limit;
// write only while no item is in flight.
// Throughput: one item per cycle while the result is taken. The pipeline holds
// 4 front stages (magnitudes, squares, sums, range flags), 33 root
// stages (one root bit per stage, three roots side by side), one near-zero
// stage, 63 restoring divider stages (one quotient bit per stage, two lanes),
// 3 product stages and the output register.
// The pipeline advances as a whole: when the result register holds an item
// that is not taken, every stage holds and s_ready drops in the same cycle,
// so nothing is lost or repeated. Reset clears all valid bits and loads
// register defaults.
module cylinder_vortex_force_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cvf_pkg::in_item_t     s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cvf_pkg::out_item_t    m_data,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_idx,
    input  logic [31:0]           cfg_data
);
    localparam int DW = cvf_pkg::DW;
    localparam int FB = cvf_pkg::FB;
    localparam int DF = cvf_pkg::DIR_FRAC;
    localparam int SW = 2*DW+2;          // squares and sums
    localparam int RW = DW+1;            // root width
    localparam int NR = RW;              // root stages
    localparam int NUMW = DW+1;          // |num| width
    localparam int DIVW = NUMW+DF;       // dividend width
    localparam int NQ = DIVW;            // quotient bits
    localparam int NPIPE = 4 + NR + 1 + NQ + 3;

    // configuration registers
    logic [DW-2:0]        radius_reg, length_reg;
    logic signed [DW-1:0] coef_reg;
    logic [15:0]          nzl_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= (DW-1)'(1 << FB);
            length_reg <= (DW-1)'(1 << FB);
            coef_reg   <= DW'(1 << FB);
            nzl_reg    <= 16'd1;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                cvf_pkg::REG_RADIUS: radius_reg <= cfg_data[DW-2:0];
                cvf_pkg::REG_LENGTH: length_reg <= cfg_data[DW-2:0];
                cvf_pkg::REG_COEF:   coef_reg   <= cfg_data[DW-1:0];
                cvf_pkg::REG_NZL:    nzl_reg    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // global advance: stall only when result is held
    logic adv;
    assign adv = !m_valid || m_ready;
    assign s_ready = adv;

    logic [NPIPE-1:0] v_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[NPIPE-2:0], s_valid};
    end

    // stage 1: magnitudes and span test
    logic [DW-1:0] ax_reg, ay_reg, avx_reg, avy_reg, avz_reg;
    logic signed [DW:0] dnum_reg, snum_reg;
    logic span_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg  <= s_data.pos_x[DW-1] ? DW'(-s_data.pos_x) : s_data.pos_x;
            ay_reg  <= s_data.pos_y[DW-1] ? DW'(-s_data.pos_y) : s_data.pos_y;
            avx_reg <= s_data.vel_x[DW-1] ? DW'(-s_data.vel_x) : s_data.vel_x;
            avy_reg <= s_data.vel_y[DW-1] ? DW'(-s_data.vel_y) : s_data.vel_y;
            avz_reg <= s_data.vel_z[DW-1] ? DW'(-s_data.vel_z) : s_data.vel_z;
            dnum_reg <= (DW+1)'(s_data.pos_y) - (DW+1)'(s_data.pos_x);
            snum_reg <= -((DW+1)'(s_data.pos_x) + (DW+1)'(s_data.pos_y));
            span_reg <= !s_data.pos_z[DW-1] && (s_data.pos_z[DW-2:0] <= length_reg);
        end
    end

    // stage 2: squares
    logic [2*DW-1:0] x2_reg, y2_reg, vx2_reg, vy2_reg, vz2_reg, r2_reg;
    logic signed [DW:0] dnum2_reg, snum2_reg;
    logic span2_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            x2_reg  <= ax_reg * ax_reg;
            y2_reg  <= ay_reg * ay_reg;
            vx2_reg <= avx_reg * avx_reg;
            vy2_reg <= avy_reg * avy_reg;
            vz2_reg <= avz_reg * avz_reg;
            r2_reg  <= {1'b0, radius_reg} * {1'b0, radius_reg};
            dnum2_reg <= dnum_reg;
            snum2_reg <= snum_reg;
            span2_reg <= span_reg;
        end
    end

    // stage 3: sums
    logic [SW-1:0] s_reg, v2_reg;
    logic [2*DW-1:0] r2b_reg;
    logic signed [DW:0] dnum3_reg, snum3_reg;
    logic span3_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            s_reg  <= SW'(x2_reg) + SW'(y2_reg);
            v2_reg <= SW'(vx2_reg) + SW'(vy2_reg) + SW'(vz2_reg);
            r2b_reg <= r2_reg;
            dnum3_reg <= dnum2_reg;
            snum3_reg <= snum2_reg;
            span3_reg <= span2_reg;
        end
    end

    // stage 4: inside and near-zero flags
    logic [SW-1:0] s4_reg, v24_reg;
    logic signed [DW:0] dnum4_reg, snum4_reg;
    logic inf4_reg, nz4_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            s4_reg  <= s_reg;
            v24_reg <= v2_reg;
            dnum4_reg <= dnum3_reg;
            snum4_reg <= snum3_reg;
            inf4_reg <= span3_reg && (s_reg <= SW'(r2b_reg));
            nz4_reg  <= (s_reg >> FB) <= SW'(nzl_reg);
        end
    end

    // bit-serial roots: sqrt(S), sqrt(2S) and sqrt(v2) one bit per stage
    logic [SW-1:0] rs_a [0:NR], rq_a [0:NR], rv_a [0:NR];
    logic [RW-1:0] rs_r [0:NR], rq_r [0:NR], rv_r [0:NR];
    logic signed [DW:0] dn_a [0:NR], sn_a [0:NR];
    logic inf_a [0:NR], nz_a [0:NR];
    assign rs_a[0] = s4_reg;
    assign rq_a[0] = {s4_reg[SW-2:0], 1'b0};
    assign rv_a[0] = v24_reg;
    assign rs_r[0] = '0;
    assign rq_r[0] = '0;
    assign rv_r[0] = '0;
    assign dn_a[0] = dnum4_reg;
    assign sn_a[0] = snum4_reg;
    assign inf_a[0] = inf4_reg;
    assign nz_a[0] = nz4_reg;

    for (genvar i = 0; i < NR; i++) begin : g_root
        localparam int B = NR-1-i;
        logic [RW-1:0] cs, cq, cv;
        logic [SW-1:0] rs_a_reg, rq_a_reg, rv_a_reg;
        logic [RW-1:0] rs_r_reg, rq_r_reg, rv_r_reg;
        logic signed [DW:0] dn_reg, sn_reg;
        logic inf_reg, nz_reg;
        assign cs = rs_r[i] | (RW'(1) << B);
        assign cq = rq_r[i] | (RW'(1) << B);
        assign cv = rv_r[i] | (RW'(1) << B);
        always_ff @(posedge aclk) begin
            if (adv) begin
                rs_a_reg <= rs_a[i];
                rq_a_reg <= rq_a[i];
                rv_a_reg <= rv_a[i];
                rs_r_reg <= (SW'(cs) * SW'(cs) <= rs_a[i]) ? cs : rs_r[i];
                rq_r_reg <= (SW'(cq) * SW'(cq) <= rq_a[i]) ? cq : rq_r[i];
                rv_r_reg <= (SW'(cv) * SW'(cv) <= rv_a[i]) ? cv : rv_r[i];
                dn_reg <= dn_a[i];
                sn_reg <= sn_a[i];
                inf_reg <= inf_a[i];
                nz_reg <= nz_a[i];
            end
        end
        assign rs_a[i+1] = rs_a_reg;
        assign rq_a[i+1] = rq_a_reg;
        assign rv_a[i+1] = rv_a_reg;
        assign rs_r[i+1] = rs_r_reg;
        assign rq_r[i+1] = rq_r_reg;
        assign rv_r[i+1] = rv_r_reg;
        assign dn_a[i+1] = dn_reg;
        assign sn_a[i+1] = sn_reg;
        assign inf_a[i+1] = inf_reg;
        assign nz_a[i+1] = nz_reg;
    end

    // root results and the near-zero radius test
    logic [RW-1:0] q5_reg, sp5_reg;
    logic signed [DW:0] dn5_reg, sn5_reg;
    logic inf5_reg, zero5_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            q5_reg  <= rq_r[NR];
            sp5_reg <= rv_r[NR];
            dn5_reg <= dn_a[NR];
            sn5_reg <= sn_a[NR];
            inf5_reg <= inf_a[NR];
            zero5_reg <= !inf_a[NR] || nz_a[NR] || (rs_r[NR] <= RW'(nzl_reg));
        end
    end

    // restoring dividers, one quotient bit per stage, two lanes
    logic [DIVW-1:0] dva [0:NQ], dvb [0:NQ];
    logic [RW:0]     rma [0:NQ], rmb [0:NQ];
    logic [DIVW-1:0] qa [0:NQ], qb [0:NQ];
    logic [RW-1:0]   dq [0:NQ], dsp [0:NQ];
    logic            nga [0:NQ], ngb [0:NQ], dinf [0:NQ], dz [0:NQ];
    logic [NUMW-1:0] mna, mnb;
    assign mna = dn5_reg[DW] ? NUMW'(-dn5_reg) : NUMW'(dn5_reg);
    assign mnb = sn5_reg[DW] ? NUMW'(-sn5_reg) : NUMW'(sn5_reg);
    assign dva[0] = {mna, {DF{1'b0}}};
    assign dvb[0] = {mnb, {DF{1'b0}}};
    assign rma[0] = '0;
    assign rmb[0] = '0;
    assign qa[0] = '0;
    assign qb[0] = '0;
    assign dq[0] = q5_reg;
    assign dsp[0] = sp5_reg;
    assign nga[0] = dn5_reg[DW];
    assign ngb[0] = sn5_reg[DW];
    assign dinf[0] = inf5_reg;
    assign dz[0] = zero5_reg || (q5_reg == '0);
    for (genvar i = 0; i < NQ; i++) begin : g_div
        logic [RW+1:0] trya, tryb;
        logic [DIVW-1:0] dva_reg, dvb_reg, qa_reg, qb_reg;
        logic [RW:0] rma_reg, rmb_reg;
        logic [RW-1:0] dq_reg, dsp_reg;
        logic nga_reg, ngb_reg, inf_reg, z_reg;
        assign trya = {rma[i], dva[i][DIVW-1]};
        assign tryb = {rmb[i], dvb[i][DIVW-1]};
        always_ff @(posedge aclk) begin
            if (adv) begin
                dva_reg <= {dva[i][DIVW-2:0], 1'b0};
                dvb_reg <= {dvb[i][DIVW-2:0], 1'b0};
                if (trya >= (RW+2)'(dq[i])) begin
                    rma_reg <= (RW+1)'(trya - (RW+2)'(dq[i]));
                    qa_reg <= {qa[i][DIVW-2:0], 1'b1};
                end else begin
                    rma_reg <= (RW+1)'(trya);
                    qa_reg <= {qa[i][DIVW-2:0], 1'b0};
                end
                if (tryb >= (RW+2)'(dq[i])) begin
                    rmb_reg <= (RW+1)'(tryb - (RW+2)'(dq[i]));
                    qb_reg <= {qb[i][DIVW-2:0], 1'b1};
                end else begin
                    rmb_reg <= (RW+1)'(tryb);
                    qb_reg <= {qb[i][DIVW-2:0], 1'b0};
                end
                dq_reg <= dq[i];
                dsp_reg <= dsp[i];
                nga_reg <= nga[i];
                ngb_reg <= ngb[i];
                inf_reg <= dinf[i];
                z_reg <= dz[i];
            end
        end
        assign dva[i+1] = dva_reg;
        assign dvb[i+1] = dvb_reg;
        assign rma[i+1] = rma_reg;
        assign rmb[i+1] = rmb_reg;
        assign qa[i+1] = qa_reg;
        assign qb[i+1] = qb_reg;
        assign dq[i+1] = dq_reg;
        assign dsp[i+1] = dsp_reg;
        assign nga[i+1] = nga_reg;
        assign ngb[i+1] = ngb_reg;
        assign dinf[i+1] = inf_reg;
        assign dz[i+1] = z_reg;
    end

    // final stage a: coefficient times speed, below 2^63
    logic [DW:0] cmag;
    assign cmag = coef_reg[DW-1] ? -((DW+1)'(coef_reg)) : (DW+1)'(coef_reg);
    logic [2*DW-1:0] t_reg;
    logic [DW-1:0] da_reg, db_reg;
    logic fna_reg, fnb_reg, finf_reg, fz_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg  <= (2*DW)'(cmag) * (2*DW)'(dsp[NQ]);
            da_reg <= DW'(qa[NQ]);
            db_reg <= DW'(qb[NQ]);
            fna_reg <= coef_reg[DW-1] ^ nga[NQ];
            fnb_reg <= coef_reg[DW-1] ^ ngb[NQ];
            finf_reg <= dinf[NQ];
            fz_reg <= dz[NQ];
        end
    end

    // final stage b: direction times low and high halves of the product
    logic [2*DW-1:0] pal_reg, pah_reg, pbl_reg, pbh_reg;
    logic hna_reg, hnb_reg, hinf_reg, hz_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            pal_reg <= t_reg[DW-1:0] * da_reg;
            pah_reg <= t_reg[2*DW-1:DW] * da_reg;
            pbl_reg <= t_reg[DW-1:0] * db_reg;
            pbh_reg <= t_reg[2*DW-1:DW] * db_reg;
            hna_reg <= fna_reg;
            hnb_reg <= fnb_reg;
            hinf_reg <= finf_reg;
            hz_reg <= fz_reg;
        end
    end

    // final stage c: combine the halves
    localparam int PW = 3*DW+4;
    logic [PW-1:0] pa_reg, pb_reg;
    logic gna_reg, gnb_reg, ginf_reg, gz_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_reg <= PW'(pal_reg) + (PW'(pah_reg) << DW);
            pb_reg <= PW'(pbl_reg) + (PW'(pbh_reg) << DW);
            gna_reg <= hna_reg;
            gnb_reg <= hnb_reg;
            ginf_reg <= hinf_reg;
            gz_reg <= hz_reg;
        end
    end

    // output stage: scale, saturate, sign
    function automatic logic [DW-1:0] sat_out(input logic [PW-1:0] p, input logic neg);
        logic [PW-1:0] m, lim;
        m = p >> (FB + DF);
        lim = neg ? (PW'(1) << (DW-1)) : ((PW'(1) << (DW-1)) - PW'(1));
        if (m > lim) m = lim;
        return neg ? DW'(-m) : DW'(m);
    endfunction

    logic m_valid_reg;
    cvf_pkg::out_item_t m_data_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= v_reg[NPIPE-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg.force_x <= gz_reg ? '0 : sat_out(pa_reg, gna_reg);
            m_data_reg.force_y <= gz_reg ? '0 : sat_out(pb_reg, gnb_reg);
            m_data_reg.in_field <= ginf_reg;
        end
    end
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;
endmodule

// File: rtl/core/cvf_checker.sv
// port-level checker for the vortex force core, bound to the top level
// depends on cvf_pkg and the macros header
`timescale 1ns / 1ps
`include "cylinder_vortex_force_core_macros.svh"
module cvf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input cvf_pkg::out_item_t m_data
);
    // a held result keeps its value
    `CVF_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "result changed while stalled")
    // input side is ready whenever the output is free
    `CVF_ASSERT(a_ready_free, !m_valid |-> s_ready, "input blocked with empty output")
    // zero force whenever the particle lay outside
    `CVF_ASSERT(a_outside_zero, m_valid && !m_data.in_field |-> m_data.force_x == '0 && m_data.force_y == '0, "force outside cylinder")
    // stall of the output stalls the input
    `CVF_ASSERT(a_stall, m_valid && !m_ready |-> !s_ready, "input taken during stall")
    // reset empties the result register
    `CVF_ASSERT_ALL(a_reset_clear, !aresetn |=> !m_valid, "result valid after reset")
endmodule

bind cylinder_vortex_force_core cvf_checker u_cvf_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
